/* sv/mme_pkg.sv */
// shared types and constants for the matrix multiply engine
`timescale 1ns / 1ps
`default_nettype none

package mme_pkg;

  // default sizing handed down from the top level
  localparam int MAX_DIM_DEF    = 8;
  localparam int ELEM_WIDTH_DEF = 16;

  // fixed field widths
  localparam int OP_W        = 2;
  localparam int IDX_FIELD_W = 3;
  localparam int VAL_W       = 16;
  localparam int OUT_W       = 36;
  localparam int CFG_W       = 4;
  localparam int CFG_IDX_W   = 2;

  // request opcodes
  localparam logic [OP_W-1:0] OP_WRITE_A = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE_B = 2'd1;
  localparam logic [OP_W-1:0] OP_START   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd2;

  localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

  // depth of the queue between front and back
  localparam int Q_DEPTH = 2;

  typedef struct packed {
    logic [OP_W-1:0]        opcode;
    logic [IDX_FIELD_W-1:0] row_index;
    logic [IDX_FIELD_W-1:0] col_index;
    logic signed [VAL_W-1:0] element_value;
  } in_req_t;

  typedef struct packed {
    logic [IDX_FIELD_W-1:0] out_row;
    logic [IDX_FIELD_W-1:0] out_col;
    logic signed [OUT_W-1:0] product_value;
    logic                   last;
  } out_rsp_t;

  typedef struct packed {
    logic [CFG_W-1:0] rows;
    logic [CFG_W-1:0] inner;
    logic [CFG_W-1:0] cols;
  } dims_t;

endpackage

`default_nettype wire

/* sv/mme_ram.sv */
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module mme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/mme_front.sv */
// front end: takes requests, drops the ones that do nothing, queues the rest
`timescale 1ns / 1ps
`default_nettype none

module mme_front #(
  parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire mme_pkg::in_req_t in_data,
  output logic                  q_valid,
  output mme_pkg::in_req_t      q_data,
  input  wire logic             q_pop
);

  import mme_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  in_req_t            q_mem_r [Q_DEPTH];
  logic [PTR_W-1:0]   wptr_r, wptr_nxt;
  logic [PTR_W-1:0]   rptr_r, rptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               in_range;
  logic               keep;
  logic               push;
  logic               pop;

  assign in_ready = (cnt_r != CNT_W'(Q_DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_data   = q_mem_r[rptr_r];

  // writes outside the stores and the unused opcode are dropped here
  assign in_range = (32'(in_data.row_index) < MAX_DIM) && (32'(in_data.col_index) < MAX_DIM);
  assign keep     = (in_data.opcode == OP_START) ||
                    (((in_data.opcode == OP_WRITE_A) || (in_data.opcode == OP_WRITE_B)) &&
                     in_range);
  assign push     = in_valid && in_ready && keep;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wptr_r] <= in_data;
    end
  end

endmodule

`default_nettype wire

/* sv/mme_back.sv */
// back end: matrix stores, multiply-accumulate sequencer and result register
`timescale 1ns / 1ps
`default_nettype none

module mme_back #(
  parameter int MAX_DIM    = mme_pkg::MAX_DIM_DEF,
  parameter int ELEM_WIDTH = mme_pkg::ELEM_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mme_pkg::dims_t   dims,
  input  wire logic             q_valid,
  input  wire mme_pkg::in_req_t q_data,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output mme_pkg::out_rsp_t     out_data
);

  import mme_pkg::*;

  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PROD_W = 2 * ELEM_WIDTH;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WAIT  = 2'd1;
  localparam logic [1:0] S_ISSUE = 2'd2;
  localparam logic [1:0] S_DRAIN = 2'd3;

  // size register to last index: zero counts as one, large values saturate
  function automatic logic [IDX_W-1:0] last_idx(input logic [CFG_W-1:0] v);
    logic [IDX_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (32'(v) > MAX_DIM) begin
      r = IDX_W'(MAX_DIM - 1);
    end else begin
      r = IDX_W'(32'(v) - 1);
    end
    return r;
  endfunction

  logic [1:0]              state_r, state_nxt;
  logic [IDX_W-1:0]        i_r, i_nxt;
  logic [IDX_W-1:0]        k_r, k_nxt;
  logic [IDX_W-1:0]        j_r, j_nxt;
  logic [IDX_W-1:0]        nm1_r, nm1_nxt;
  logic [IDX_W-1:0]        pm1_r, pm1_nxt;
  logic [IDX_W-1:0]        lm1_r, lm1_nxt;

  logic                    p1_valid_r, p1_first_r, p1_last_r;
  logic                    p2_valid_r, p2_first_r, p2_last_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [OUT_W-1:0]        acc_r, acc_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_rsp_t                out_r;

  logic                    issue;
  logic                    load_out;
  logic                    we_a, we_b;
  logic [ADDR_W-1:0]       waddr;
  logic [ELEM_WIDTH-1:0]   wdata;
  logic [ADDR_W-1:0]       raddr_a, raddr_b;
  logic [ELEM_WIDTH-1:0]   rdata_a, rdata_b;
  logic signed [PROD_W-1:0] prod_nxt;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // stores are written from the queue only while no product is in flight
  assign q_pop = (state_r == S_IDLE) && q_valid;
  assign we_a  = q_pop && (q_data.opcode == OP_WRITE_A);
  assign we_b  = q_pop && (q_data.opcode == OP_WRITE_B);
  assign waddr = ADDR_W'(32'(q_data.row_index) * MAX_DIM + 32'(q_data.col_index));
  assign wdata = ELEM_WIDTH'($unsigned(q_data.element_value));

  assign issue   = (state_r == S_ISSUE);
  assign raddr_a = ADDR_W'(32'(i_r) * MAX_DIM + 32'(j_r));
  assign raddr_b = ADDR_W'(32'(j_r) * MAX_DIM + 32'(k_r));

  mme_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  mme_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  assign prod_nxt = $signed(rdata_a) * $signed(rdata_b);
  assign acc_nxt  = (p2_first_r ? '0 : acc_r) + OUT_W'(prod_r);
  assign load_out = p2_valid_r && p2_last_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    nm1_nxt   = nm1_r;
    pm1_nxt   = pm1_r;
    lm1_nxt   = lm1_r;
    case (state_r)
      S_IDLE: begin
        if (q_pop && (q_data.opcode == OP_START)) begin
          nm1_nxt   = last_idx(dims.rows);
          pm1_nxt   = last_idx(dims.inner);
          lm1_nxt   = last_idx(dims.cols);
          i_nxt     = '0;
          k_nxt     = '0;
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        // result register is free by the time this entry lands
        if (!out_valid_r || out_ready) begin
          j_nxt     = '0;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (j_r == pm1_r) begin
          state_nxt = S_DRAIN;
        end else begin
          j_nxt = j_r + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        if (load_out) begin
          if (k_r == lm1_r) begin
            k_nxt = '0;
            if (i_r == nm1_r) begin
              state_nxt = S_IDLE;
            end else begin
              i_nxt     = i_r + IDX_W'(1);
              state_nxt = S_WAIT;
            end
          end else begin
            k_nxt     = k_r + IDX_W'(1);
            state_nxt = S_WAIT;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      p1_valid_r  <= 1'b0;
      p2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      p1_valid_r  <= issue;
      p2_valid_r  <= p1_valid_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    k_r        <= k_nxt;
    j_r        <= j_nxt;
    nm1_r      <= nm1_nxt;
    pm1_r      <= pm1_nxt;
    lm1_r      <= lm1_nxt;
    p1_first_r <= (j_r == '0);
    p1_last_r  <= (j_r == pm1_r);
    p2_first_r <= p1_first_r;
    p2_last_r  <= p1_last_r;
    prod_r     <= prod_nxt;
    if (p2_valid_r) begin
      acc_r <= acc_nxt;
    end
    if (load_out) begin
      out_r.out_row       <= IDX_FIELD_W'(i_r);
      out_r.out_col       <= IDX_FIELD_W'(k_r);
      out_r.product_value <= acc_nxt;
      out_r.last          <= (i_r == nm1_r) && (k_r == lm1_r);
    end
  end

endmodule

`default_nettype wire

/* sv/matrix_multiply_engine_unit.sv */
// top level of the fixed-point matrix multiply engine
`timescale 1ns / 1ps
`default_nettype none

// Loads matrix A and matrix B one Q8.8 element per request and, on a start
// request, returns every entry of A times B in row-major order as exact Q20.16,
// with last set on the final entry. Sizes come from the rows, inner and cols
// registers, sampled when the start request reaches the back end.
// Write requests go through a two-entry queue and are taken one per cycle
// while it has room. One multiply-accumulate unit walks the inner dimension
// one term per cycle, behind the registered read of the two element rams,
// with the inner size taken as 1 when zero and as MAX_DIM when larger.
// Entries that were never written read back as whatever the ram holds.
module matrix_multiply_engine_unit #(
  parameter int MAX_DIM    = mme_pkg::MAX_DIM_DEF,
  parameter int ELEM_WIDTH = mme_pkg::ELEM_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire mme_pkg::in_req_t                  in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output mme_pkg::out_rsp_t                      out_data,
  input  wire logic                              cfg_we,
  input  wire logic [mme_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mme_pkg::CFG_W-1:0]         cfg_data
);

  import mme_pkg::*;

  dims_t   dims_r, dims_nxt;
  logic    q_valid;
  in_req_t q_data;
  logic    q_pop;

  always_comb begin
    dims_nxt = dims_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_ROWS:  dims_nxt.rows  = cfg_data;
        CFG_INNER: dims_nxt.inner = cfg_data;
        CFG_COLS:  dims_nxt.cols  = cfg_data;
        default:   dims_nxt = dims_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r.rows  <= DIM_RESET;
      dims_r.inner <= DIM_RESET;
      dims_r.cols  <= DIM_RESET;
    end else begin
      dims_r <= dims_nxt;
    end
  end

  mme_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  mme_back #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .dims      (dims_r),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* sv/mme_checker.sv */
// port-level checks on the result stream of the matrix multiply engine
`timescale 1ns / 1ps
`default_nettype none

module mme_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire mme_pkg::out_rsp_t out_data
);

  import mme_pkg::*;

  logic                   expect_first_r, expect_first_nxt;
  logic [IDX_FIELD_W-1:0] prev_row_r, prev_col_r;
  logic                   take;

  assign take = out_valid && out_ready;

  always_comb begin
    expect_first_nxt = expect_first_r;
    if (take) begin
      expect_first_nxt = out_data.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_first_r <= 1'b1;
    end else begin
      expect_first_r <= expect_first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      prev_row_r <= out_data.out_row;
      prev_col_r <= out_data.out_col;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // each product starts at the top-left entry
  a_first_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && expect_first_r |-> out_data.out_row == '0 && out_data.out_col == '0)
    else $error("product did not start at row 0, column 0");

  // entries walk row-major
  a_row_major: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !expect_first_r |->
      (out_data.out_row == prev_row_r && out_data.out_col == prev_col_r + IDX_FIELD_W'(1)) ||
      (out_data.out_row == prev_row_r + IDX_FIELD_W'(1) && out_data.out_col == '0))
    else $error("product entries out of order");

endmodule

bind matrix_multiply_engine_unit mme_checker u_mme_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

/* tb/tb.sv */
// testbench for the matrix multiply engine: directed table, random load/start jobs, self-check
`timescale 1ns / 1ps

module tb;
  import mme_pkg::*;

  localparam int MAX_DIM = MAX_DIM_DEF;
  localparam int ITEM_TARGET = 470;
  localparam int SETTLE = 16;
  localparam int DRAIN = 32;
  localparam int IDLE_PCT = 24;
  localparam int CALM_FROM = 200;
  localparam int CALM_LEN = 80;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef enum logic {STEP_CFG, STEP_REQ} step_kind_e;

  typedef struct {
    step_kind_e              kind;
    logic [CFG_IDX_W-1:0]    sel;
    logic [CFG_W-1:0]        val;
    in_req_t                 req;
    bit                      typed;
    logic signed [OUT_W-1:0] want;
  } dir_step_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_req_t              in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_rsp_t             out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // shadow of the engine: element stores and size registers
  logic signed [VAL_W-1:0] a_mat [MAX_DIM][MAX_DIM];
  logic signed [VAL_W-1:0] b_mat [MAX_DIM][MAX_DIM];
  bit                      a_loaded [MAX_DIM][MAX_DIM];
  bit                      b_loaded [MAX_DIM][MAX_DIM];
  logic [CFG_W-1:0]        rows_cfg = DIM_RESET;
  logic [CFG_W-1:0]        inner_cfg = DIM_RESET;
  logic [CFG_W-1:0]        cols_cfg = DIM_RESET;

  out_rsp_t product_q [$];
  dir_step_t dir_steps [$];

  int  err_count = 0;
  int  items_sent = 0;
  int  starts_sent = 0;
  int  entries_seen = 0;
  bit  calm = 1'b0;
  bit  calm_done = 1'b0;

  matrix_multiply_engine_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int eff_dim(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic in_req_t mk_req(logic [OP_W-1:0] op, int row, int col,
                                     logic [VAL_W-1:0] v);
    in_req_t r;
    r.opcode        = op;
    r.row_index     = IDX_FIELD_W'(row);
    r.col_index     = IDX_FIELD_W'(col);
    r.element_value = v;
    return r;
  endfunction

  function automatic dir_step_t req_step(logic [OP_W-1:0] op, int row, int col,
                                         logic [VAL_W-1:0] v);
    dir_step_t s;
    s.kind  = STEP_REQ;
    s.sel   = CFG_ROWS;
    s.val   = '0;
    s.req   = mk_req(op, row, col, v);
    s.typed = 1'b0;
    s.want  = '0;
    return s;
  endfunction

  function automatic dir_step_t start_want(logic signed [OUT_W-1:0] want);
    dir_step_t s;
    s = req_step(OP_START, 0, 0, '0);
    s.typed = 1'b1;
    s.want  = want;
    return s;
  endfunction

  function automatic dir_step_t cfg_step(logic [CFG_IDX_W-1:0] sel, logic [CFG_W-1:0] val);
    dir_step_t s;
    s = req_step(OP_UNUSED, 0, 0, '0);
    s.kind = STEP_CFG;
    s.sel  = sel;
    s.val  = val;
    return s;
  endfunction

  function automatic logic [VAL_W-1:0] pick_elem();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 16'h7FFF;
    if (r < 20) return 16'h8000;
    if (r < 25) return 16'h0000;
    if (r < 30) return 16'hFFFF;
    return VAL_W'($urandom);
  endfunction

  function automatic logic [CFG_W-1:0] pick_dim();
    int r;
    r = $urandom_range(99);
    if (r < 6) return 4'd0;
    if (r < 12) return CFG_W'($urandom_range(15, 9));
    if (r < 20) return 4'd8;
    if (r < 30) return 4'd1;
    if (r < 40) return CFG_W'($urandom_range(7, 5));
    return CFG_W'($urandom_range(4, 2));
  endfunction

  // applies one accepted request to the shadow stores, queuing product entries on start
  task automatic apply_req(in_req_t r);
    int n, p, l;
    longint acc;
    out_rsp_t e;
    case (r.opcode)
      OP_WRITE_A: a_mat[r.row_index][r.col_index] = r.element_value;
      OP_WRITE_B: b_mat[r.row_index][r.col_index] = r.element_value;
      OP_START: begin
        n = eff_dim(rows_cfg);
        p = eff_dim(inner_cfg);
        l = eff_dim(cols_cfg);
        for (int i = 0; i < n; i++) begin
          for (int k = 0; k < l; k++) begin
            acc = 0;
            for (int j = 0; j < p; j++)
              acc += longint'(a_mat[i][j]) * longint'(b_mat[j][k]);
            e.out_row       = IDX_FIELD_W'(i);
            e.out_col       = IDX_FIELD_W'(k);
            e.product_value = acc[OUT_W-1:0];
            e.last          = (i == n - 1) && (k == l - 1);
            product_q.push_back(e);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_err(string msg);
    err_count++;
    if (err_count <= 60) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // sends one request; valid stays high afterwards until the next call or a config write
  task automatic send_req(in_req_t r, bit typed, logic signed [OUT_W-1:0] want);
    out_rsp_t e;
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    if (r.opcode != OP_UNUSED) items_sent++;
    if (r.opcode == OP_START) starts_sent++;
    if (r.opcode == OP_WRITE_A) a_loaded[r.row_index][r.col_index] = 1'b1;
    if (r.opcode == OP_WRITE_B) b_loaded[r.row_index][r.col_index] = 1'b1;
    if (typed) begin
      e.out_row       = '0;
      e.out_col       = '0;
      e.product_value = want;
      e.last          = 1'b1;
      product_q.push_back(e);
      // keep the shadow stores in step, the expectation is the typed one
      if (r.opcode != OP_START) apply_req(r);
    end else begin
      apply_req(r);
    end
  endtask

  // register writes only once the engine has drained
  task automatic cfg_write(logic [CFG_IDX_W-1:0] sel, logic [CFG_W-1:0] val);
    in_valid <= 1'b0;
    while (product_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    @(posedge clk);
    case (sel)
      CFG_ROWS:  rows_cfg = val;
      CFG_INNER: inner_cfg = val;
      CFG_COLS:  cols_cfg = val;
      default: ;
    endcase
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    out_rsp_t exp_e;
    if (rst_n && out_valid && out_ready) begin
      entries_seen++;
      if (product_q.size() == 0) begin
        report_err($sformatf("product entry %0d with nothing pending", entries_seen));
      end else begin
        exp_e = product_q.pop_front();
        if (out_data.out_row !== exp_e.out_row)
          report_err($sformatf("entry %0d out_row %0d, want %0d",
                               entries_seen, out_data.out_row, exp_e.out_row));
        if (out_data.out_col !== exp_e.out_col)
          report_err($sformatf("entry %0d out_col %0d, want %0d",
                               entries_seen, out_data.out_col, exp_e.out_col));
        if (out_data.product_value !== exp_e.product_value)
          report_err($sformatf("entry %0d product_value %0d, want %0d",
                               entries_seen, out_data.product_value,
                               exp_e.product_value));
        if (out_data.last !== exp_e.last)
          report_err($sformatf("entry %0d last %0b, want %0b",
                               entries_seen, out_data.last, exp_e.last));
      end
    end
  end

  initial begin : stim
    in_req_t loads [$];
    in_req_t tmp;
    int n, p, l, y, job;

    // 1x1x1 extremes first, then a single row against eight columns
    dir_steps.push_back(cfg_step(CFG_ROWS, 4'd1));
    dir_steps.push_back(cfg_step(CFG_INNER, 4'd1));
    dir_steps.push_back(cfg_step(CFG_COLS, 4'd1));
    dir_steps.push_back(req_step(OP_WRITE_A, 0, 0, 16'h7FFF));
    dir_steps.push_back(req_step(OP_WRITE_B, 0, 0, 16'h7FFF));
    dir_steps.push_back(start_want(36'sd1073676289));
    dir_steps.push_back(req_step(OP_WRITE_A, 0, 0, 16'h8000));
    dir_steps.push_back(start_want(-36'sd1073709056));
    dir_steps.push_back(req_step(OP_WRITE_B, 0, 0, 16'h8000));
    dir_steps.push_back(start_want(36'sd1073741824));
    dir_steps.push_back(req_step(OP_UNUSED, 7, 7, 16'hFFFF));
    dir_steps.push_back(req_step(OP_WRITE_A, 0, 0, 16'h0000));
    dir_steps.push_back(start_want(36'sd0));
    dir_steps.push_back(req_step(OP_WRITE_A, 0, 0, 16'h0100));
    dir_steps.push_back(cfg_step(CFG_ROWS, 4'd0));   // zero reads as one
    dir_steps.push_back(cfg_step(CFG_COLS, 4'd15));  // oversize reads as eight
    dir_steps.push_back(req_step(OP_WRITE_B, 0, 1, 16'h7FFF));
    dir_steps.push_back(req_step(OP_WRITE_B, 0, 2, 16'h8000));
    dir_steps.push_back(req_step(OP_WRITE_B, 0, 3, 16'h0001));
    dir_steps.push_back(req_step(OP_WRITE_B, 0, 4, 16'hFFFF));
    dir_steps.push_back(req_step(OP_WRITE_B, 0, 5, 16'h0080));
    dir_steps.push_back(req_step(OP_WRITE_B, 0, 6, 16'hFF80));
    dir_steps.push_back(req_step(OP_WRITE_B, 0, 7, 16'h1234));
    dir_steps.push_back(req_step(OP_START, 0, 0, 16'h0000));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_steps[s]) begin
      if (dir_steps[s].kind == STEP_CFG)
        cfg_write(dir_steps[s].sel, dir_steps[s].val);
      else
        send_req(dir_steps[s].req, dir_steps[s].typed, dir_steps[s].want);
    end

    job = 0;
    while (items_sent < ITEM_TARGET) begin
      job++;
      // one stretch of whole jobs with no idling on either side
      if (!calm && !calm_done && items_sent >= CALM_FROM) begin
        calm = 1'b1;
      end else if (calm && items_sent >= CALM_FROM + CALM_LEN) begin
        calm      = 1'b0;
        calm_done = 1'b1;
      end
      if (job == 3) begin
        cfg_write(CFG_ROWS, 4'd8);
        cfg_write(CFG_INNER, 4'd8);
        cfg_write(CFG_COLS, 4'd8);
      end else if (job == 6) begin
        cfg_write(CFG_ROWS, 4'd15);
        cfg_write(CFG_INNER, 4'd0);
        cfg_write(CFG_COLS, 4'd9);
      end else if (job == 1 || $urandom_range(2) == 0) begin
        cfg_write(CFG_ROWS, pick_dim());
        cfg_write(CFG_INNER, pick_dim());
        cfg_write(CFG_COLS, pick_dim());
      end
      n = eff_dim(rows_cfg);
      p = eff_dim(inner_cfg);
      l = eff_dim(cols_cfg);

      // region that the start will read, always loaded before the start goes out
      loads.delete();
      for (int i = 0; i < n; i++)
        for (int j = 0; j < p; j++)
          if (!a_loaded[i][j] || $urandom_range(9) < 7)
            loads.push_back(mk_req(OP_WRITE_A, i, j, pick_elem()));
      for (int j = 0; j < p; j++)
        for (int k = 0; k < l; k++)
          if (!b_loaded[j][k] || $urandom_range(9) < 7)
            loads.push_back(mk_req(OP_WRITE_B, j, k, pick_elem()));
      repeat ($urandom_range(3)) begin
        case ($urandom_range(2))
          0: loads.push_back(mk_req(OP_UNUSED, $urandom_range(7), $urandom_range(7),
                                    VAL_W'($urandom)));
          1: loads.push_back(mk_req(OP_WRITE_A, $urandom_range(7), $urandom_range(7),
                                    pick_elem()));
          default: loads.push_back(mk_req(OP_WRITE_B, $urandom_range(7),
                                          $urandom_range(7), pick_elem()));
        endcase
      end
      for (int x = loads.size() - 1; x > 0; x--) begin
        y = $urandom_range(x);
        tmp = loads[x];
        loads[x] = loads[y];
        loads[y] = tmp;
      end
      foreach (loads[q]) send_req(loads[q], 1'b0, '0);

      // some jobs are abandoned after loading, some start twice
      if ($urandom_range(99) >= 8) begin
        send_req(mk_req(OP_START, $urandom_range(7), $urandom_range(7), pick_elem()),
                 1'b0, '0);
        if ($urandom_range(99) < 8)
          send_req(mk_req(OP_START, 0, 0, '0), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (product_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("run covered %0d requests, %0d multiplies, %0d product entries checked",
             items_sent, starts_sent, entries_seen);
    $display("sizes 1..8 per dimension incl. zero and oversize registers, ignored opcode, "
             , "stalls on both channels");
    if (err_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

/* files.f */
sv/mme_pkg.sv
sv/mme_ram.sv
sv/mme_front.sv
sv/mme_back.sv
sv/matrix_multiply_engine_unit.sv
sv/mme_checker.sv
tb/tb.sv
